// File: sv/lts_pkg.sv
// Shared types, codes and constants for the link termination sequencer.
package lts_pkg;

  localparam logic [31:0] PERIOD_RESET = 32'd1000000;
  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [62:0] LEFT_MAX = {63{1'b1}};

  localparam int unsigned IN_DATA_W = 280;
  localparam int unsigned OUT_DATA_W = 136;
  localparam int unsigned PADDR_W = 3;

  typedef enum logic [2:0] {
    PH_CLOSED     = 3'd0,
    PH_OPEN       = 3'd1,
    PH_CLOSING    = 3'd2,
    PH_CLEANING   = 3'd3,
    PH_RESTARTING = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    EF_NONE       = 3'd0,
    EF_ARM        = 3'd1,
    EF_GAP        = 3'd2,
    EF_RESTART    = 3'd3,
    EF_INVALIDATE = 3'd4,
    EF_STOP       = 3'd5,
    EF_REARM      = 3'd6
  } effect_t;

  typedef enum logic [3:0] {
    ACT_OPEN       = 4'd0,
    ACT_ROTATE     = 4'd1,
    ACT_ADMITS     = 4'd2,
    ACT_BEGIN      = 4'd3,
    ACT_TICKET     = 4'd4,
    ACT_REMAINING  = 4'd5,
    ACT_ARMED      = 4'd6,
    ACT_GAP        = 4'd7,
    ACT_DISCONNECT = 4'd8,
    ACT_RESET      = 4'd9,
    ACT_STOPPED    = 4'd10,
    ACT_CLEANUP    = 4'd11,
    ACT_FIRED      = 4'd12,
    ACT_REARMED    = 4'd13,
    ACT_INIT       = 4'd14
  } action_t;

  localparam logic [PADDR_W-1:0] ADDR_PERIOD = '0;

  typedef struct packed {
    logic [3:0]         action;
    logic [15:0]        conn_handle;
    logic [63:0]        gen_tag;
    logic [63:0]        new_gen_tag;
    logic signed [63:0] now_time;
    logic signed [63:0] ticket_deadline;
    logic               ok_flag;
  } event_t;

  typedef struct packed {
    logic [2:0]         effect;
    logic               accepted;
    logic [62:0]        time_left;
    logic signed [63:0] deadline_out;
    logic [2:0]         phase_now;
  } result_t;

endpackage

// File: sv/lts_fsm.sv
// Sequencer state and the per-event handler.
module lts_fsm
  import lts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  event_t      ev,
  input  logic [31:0] period,
  output result_t     res
);

  phase_t      phase, phase_next;
  logic [15:0] link_handle, link_handle_next;
  logic [63:0] generation, generation_next;
  logic [63:0] deadline, deadline_next;
  logic        wd_armed, wd_armed_next;
  logic        rearm_pending, rearm_pending_next;
  logic        stop_required, stop_required_next;
  logic        cleanup_ok, cleanup_ok_next;

  logic        match, tmatch, early;
  logic [64:0] sum, diff;
  logic [63:0] begin_deadline;
  logic [62:0] left_sat;
  effect_t     eff;
  logic        acc;
  logic [62:0] left;
  logic [63:0] dout;

  assign match  = (ev.conn_handle == link_handle) && (ev.gen_tag == generation) &&
                  (ev.gen_tag != '0);
  assign tmatch = match && (ev.ticket_deadline == deadline);
  assign early  = ev.now_time < $signed(deadline);

  // Only positive overflow is possible since the period is never negative.
  assign sum = {ev.now_time[63], ev.now_time} + {33'b0, period};
  assign begin_deadline = (sum[64:63] == 2'b01) ? S64_MAX : sum[63:0];

  assign diff = {deadline[63], deadline} - {ev.now_time[63], ev.now_time};
  assign left_sat = diff[63] ? LEFT_MAX : diff[62:0];

  always_comb begin
    phase_next         = phase;
    link_handle_next   = link_handle;
    generation_next    = generation;
    deadline_next      = deadline;
    wd_armed_next      = wd_armed;
    rearm_pending_next = rearm_pending;
    stop_required_next = stop_required;
    cleanup_ok_next    = cleanup_ok;
    eff  = EF_NONE;
    acc  = 1'b0;
    left = '0;
    dout = '0;

    unique case (ev.action)
      ACT_OPEN: begin
        if (phase == PH_CLOSED && ev.gen_tag != '0) begin
          phase_next         = PH_OPEN;
          link_handle_next   = ev.conn_handle;
          generation_next    = ev.gen_tag;
          deadline_next      = '0;
          wd_armed_next      = 1'b0;
          rearm_pending_next = 1'b0;
          stop_required_next = 1'b0;
          cleanup_ok_next    = 1'b0;
          acc = 1'b1;
        end
      end
      ACT_ROTATE: begin
        if (phase == PH_OPEN && match && ev.new_gen_tag != '0 &&
            ev.new_gen_tag != ev.gen_tag) begin
          generation_next    = ev.new_gen_tag;
          deadline_next      = '0;
          wd_armed_next      = 1'b0;
          rearm_pending_next = 1'b0;
          stop_required_next = 1'b0;
          cleanup_ok_next    = 1'b0;
          acc = 1'b1;
        end
      end
      ACT_ADMITS: begin
        acc = (phase == PH_OPEN) && match;
      end
      ACT_BEGIN: begin
        if (phase == PH_OPEN && match) begin
          phase_next         = PH_CLOSING;
          deadline_next      = begin_deadline;
          wd_armed_next      = 1'b0;
          rearm_pending_next = 1'b0;
          stop_required_next = 1'b1;
          cleanup_ok_next    = 1'b0;
          eff = EF_ARM;
        end
      end
      ACT_TICKET: begin
        if (phase == PH_CLOSING && match) begin
          acc  = 1'b1;
          dout = deadline;
        end
      end
      ACT_REMAINING: begin
        if (phase == PH_CLOSING && tmatch && early) left = left_sat;
      end
      ACT_ARMED: begin
        if (phase == PH_CLOSING && match && !wd_armed) begin
          if (!ev.ok_flag) begin
            phase_next         = PH_RESTARTING;
            wd_armed_next      = 1'b0;
            rearm_pending_next = 1'b0;
            cleanup_ok_next    = 1'b0;
            eff = EF_RESTART;
          end else begin
            wd_armed_next = 1'b1;
            eff = EF_GAP;
          end
        end
      end
      ACT_GAP: begin
        if (phase == PH_CLOSING && match && wd_armed && !ev.ok_flag) begin
          phase_next         = PH_RESTARTING;
          wd_armed_next      = 1'b0;
          rearm_pending_next = 1'b0;
          cleanup_ok_next    = 1'b0;
          eff = EF_RESTART;
        end
      end
      ACT_DISCONNECT, ACT_RESET: begin
        // Disconnect needs a match; the reset action acts on the phase alone.
        if (match || ev.action == ACT_RESET) begin
          if (phase == PH_OPEN) begin
            phase_next         = PH_CLEANING;
            stop_required_next = 1'b0;
            cleanup_ok_next    = 1'b1;
            eff = EF_INVALIDATE;
          end else if (phase == PH_CLOSING) begin
            phase_next         = PH_CLEANING;
            stop_required_next = 1'b1;
            cleanup_ok_next    = 1'b0;
            eff = EF_STOP;
          end
        end
      end
      ACT_STOPPED: begin
        if (phase == PH_CLEANING && match && stop_required) begin
          if (!ev.ok_flag) begin
            phase_next         = PH_RESTARTING;
            wd_armed_next      = 1'b0;
            rearm_pending_next = 1'b0;
            cleanup_ok_next    = 1'b0;
            eff = EF_RESTART;
          end else begin
            wd_armed_next      = 1'b0;
            rearm_pending_next = 1'b0;
            stop_required_next = 1'b0;
            cleanup_ok_next    = 1'b1;
            eff = EF_INVALIDATE;
          end
        end
      end
      ACT_CLEANUP: begin
        if (phase == PH_CLEANING && match && cleanup_ok && !stop_required) begin
          phase_next         = PH_CLOSED;
          link_handle_next   = '0;
          generation_next    = '0;
          deadline_next      = '0;
          wd_armed_next      = 1'b0;
          rearm_pending_next = 1'b0;
          cleanup_ok_next    = 1'b0;
        end
      end
      ACT_FIRED: begin
        if (phase == PH_CLOSING && tmatch && wd_armed && !rearm_pending) begin
          if (!early) begin
            phase_next         = PH_RESTARTING;
            wd_armed_next      = 1'b0;
            rearm_pending_next = 1'b0;
            cleanup_ok_next    = 1'b0;
            eff = EF_RESTART;
          end else begin
            rearm_pending_next = 1'b1;
            eff = EF_REARM;
          end
        end
      end
      ACT_REARMED: begin
        if (phase == PH_CLOSING && tmatch && rearm_pending) begin
          rearm_pending_next = 1'b0;
          if (!ev.ok_flag) begin
            phase_next      = PH_RESTARTING;
            wd_armed_next   = 1'b0;
            cleanup_ok_next = 1'b0;
            eff = EF_RESTART;
          end else begin
            wd_armed_next = 1'b1;
          end
        end
      end
      ACT_INIT: begin
        phase_next         = PH_CLOSED;
        link_handle_next   = '0;
        generation_next    = '0;
        deadline_next      = '0;
        wd_armed_next      = 1'b0;
        rearm_pending_next = 1'b0;
        stop_required_next = 1'b0;
        cleanup_ok_next    = 1'b0;
      end
      default: begin
      end
    endcase

    res.effect       = eff;
    res.accepted     = acc;
    res.time_left    = left;
    res.deadline_out = dout;
    res.phase_now    = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_CLOSED;
      link_handle   <= '0;
      generation    <= '0;
      deadline      <= '0;
      wd_armed      <= 1'b0;
      rearm_pending <= 1'b0;
      stop_required <= 1'b0;
      cleanup_ok    <= 1'b0;
    end else if (go) begin
      phase         <= phase_next;
      link_handle   <= link_handle_next;
      generation    <= generation_next;
      deadline      <= deadline_next;
      wd_armed      <= wd_armed_next;
      rearm_pending <= rearm_pending_next;
      stop_required <= stop_required_next;
      cleanup_ok    <= cleanup_ok_next;
    end
  end

endmodule

// File: sv/link_termination_sequencer_core.sv
// Top level: event stream in, result stream out, watchdog period register.
// An accepted beat passes the event register, then the result register behind m_tvalid.
// Throughput: one event per cycle; the event register, the handler and the result
// register form a two-stage pipeline, and the state registers update once per event.
// Backpressure on m_tready stalls both stages; s_tready stays high while either has room.
// Reset (rst, synchronous): pipeline empty, phase closed, all state zero,
// watchdog period back to 1000000 us.
module link_termination_sequencer_core
  import lts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // conn_handle[15:0], gen_tag[79:16], new_gen_tag[143:80], now_time[207:144],
  // ticket_deadline[271:208], ok_flag[272], zero fill above
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // action[3:0]
  input  logic [3:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // effect[2:0], accepted[3], time_left[66:4], deadline_out[130:67],
  // phase_now[133:131], zero fill above
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic        in_valid;
  event_t      in_ev;
  logic        advance;
  logic        go;
  result_t     res;
  result_t     out_res;
  logic [31:0] period;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_PERIOD) begin
      period <= pwdata;
    end
  end

  assign prdata = (paddr == ADDR_PERIOD) ? period : '0;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign go       = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ev.action          <= s_tuser;
      in_ev.conn_handle     <= s_tdata[15:0];
      in_ev.gen_tag         <= s_tdata[79:16];
      in_ev.new_gen_tag     <= s_tdata[143:80];
      in_ev.now_time        <= s_tdata[207:144];
      in_ev.ticket_deadline <= s_tdata[271:208];
      in_ev.ok_flag         <= s_tdata[272];
    end
  end

  lts_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .ev     (in_ev),
    .period (period),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) out_res <= res;
  end

  assign m_tdata = {2'b0, out_res.phase_now, out_res.deadline_out, out_res.time_left,
                    out_res.accepted, out_res.effect};

endmodule

// File: sv/lts_checker.sv
// Port-level checks for the sequencer core, bound to the top level.
module lts_checker
  import lts_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  logic [2:0]  eff;
  logic        acc;
  logic [62:0] left;
  logic [63:0] dout;
  logic [2:0]  ph;

  assign eff  = m_tdata[2:0];
  assign acc  = m_tdata[3];
  assign left = m_tdata[66:4];
  assign dout = m_tdata[130:67];
  assign ph   = m_tdata[133:131];

  // Hold a stalled result beat.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // Accepting events never carry a side effect.
  a_acc_no_effect: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && acc |-> eff == EF_NONE)
    else $error("accepted beat with a side effect");

  a_restart_phase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && eff == EF_RESTART |-> ph == PH_RESTARTING)
    else $error("restart effect without restarting phase");

  a_query_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && dout != '0 |-> left == '0 && ph == PH_CLOSING)
    else $error("ticket deadline returned outside a ticket query");

endmodule

bind link_termination_sequencer_core lts_checker u_lts_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: sim/tb_link_termination_sequencer_core.sv
// Self-checking testbench: event stream against a predicted teardown sequence.
module tb_link_termination_sequencer_core;
  import lts_pkg::*;

  localparam logic [3:0]  ACT_UNDEF   = 4'hF;
  localparam logic [63:0] S64_MIN     = 64'h8000_0000_0000_0000;
  localparam int unsigned STALL_LIMIT = 1000;

  class termination_scoreboard;
    logic [31:0] period;
    phase_t      cur_phase;
    logic [15:0] cur_handle;
    logic [63:0] cur_gen;
    logic [63:0] cur_deadline;
    bit          armed;
    bit          rearm_wait;
    bit          stop_needed;
    bit          cleanup_ready;
    result_t     pending_results[$];
    int unsigned errors;

    function new();
      period = PERIOD_RESET;
      errors = 0;
      clear_all();
    endfunction

    function void drop_flags();
      cur_deadline  = '0;
      armed         = 1'b0;
      rearm_wait    = 1'b0;
      stop_needed   = 1'b0;
      cleanup_ready = 1'b0;
    endfunction

    function void clear_all();
      cur_phase  = PH_CLOSED;
      cur_handle = '0;
      cur_gen    = '0;
      drop_flags();
    endfunction

    function effect_t go_restart();
      cur_phase     = PH_RESTARTING;
      armed         = 1'b0;
      rearm_wait    = 1'b0;
      cleanup_ready = 1'b0;
      return EF_RESTART;
    endfunction

    function effect_t tear_down();
      if (cur_phase == PH_OPEN) begin
        cur_phase     = PH_CLEANING;
        stop_needed   = 1'b0;
        cleanup_ready = 1'b1;
        return EF_INVALIDATE;
      end
      if (cur_phase == PH_CLOSING) begin
        cur_phase     = PH_CLEANING;
        stop_needed   = 1'b1;
        cleanup_ready = 1'b0;
        return EF_STOP;
      end
      return EF_NONE;
    endfunction

    function int results_owed();
      return pending_results.size();
    endfunction

    // Advance the predicted state by one accepted event and queue its result.
    function void note_event(event_t ev);
      result_t     r;
      logic        hit;
      logic        ticket_hit;
      logic [63:0] lim;
      logic [63:0] diff;
      r = '0;
      hit = (ev.conn_handle == cur_handle) && (ev.gen_tag == cur_gen) && (ev.gen_tag != '0);
      ticket_hit = hit && (ev.ticket_deadline == cur_deadline);
      case (ev.action)
        ACT_OPEN: if (cur_phase == PH_CLOSED && ev.gen_tag != '0) begin
          cur_phase  = PH_OPEN;
          cur_handle = ev.conn_handle;
          cur_gen    = ev.gen_tag;
          drop_flags();
          r.accepted = 1'b1;
        end
        ACT_ROTATE: if (cur_phase == PH_OPEN && hit && ev.new_gen_tag != '0 &&
                        ev.new_gen_tag != ev.gen_tag) begin
          cur_gen = ev.new_gen_tag;
          drop_flags();
          r.accepted = 1'b1;
        end
        ACT_ADMITS: r.accepted = (cur_phase == PH_OPEN) && hit;
        ACT_BEGIN: if (cur_phase == PH_OPEN && hit) begin
          // saturate the deadline at the signed maximum
          lim = S64_MAX - {32'd0, period};
          cur_phase = PH_CLOSING;
          cur_deadline = ($signed(lim) < $signed(ev.now_time)) ? S64_MAX
                                                              : ev.now_time + {32'd0, period};
          armed         = 1'b0;
          rearm_wait    = 1'b0;
          stop_needed   = 1'b1;
          cleanup_ready = 1'b0;
          r.effect = EF_ARM;
        end
        ACT_TICKET: if (cur_phase == PH_CLOSING && hit) begin
          r.accepted     = 1'b1;
          r.deadline_out = cur_deadline;
        end
        ACT_REMAINING: if (cur_phase == PH_CLOSING && ticket_hit &&
                           $signed(ev.now_time) < $signed(cur_deadline)) begin
          diff = cur_deadline - ev.now_time;
          r.time_left = (diff > S64_MAX) ? LEFT_MAX : diff[62:0];
        end
        ACT_ARMED: if (cur_phase == PH_CLOSING && hit && !armed) begin
          if (!ev.ok_flag) r.effect = go_restart();
          else begin
            armed    = 1'b1;
            r.effect = EF_GAP;
          end
        end
        ACT_GAP: if (cur_phase == PH_CLOSING && hit && armed && !ev.ok_flag)
          r.effect = go_restart();
        ACT_DISCONNECT: if (hit) r.effect = tear_down();
        ACT_RESET: r.effect = tear_down();
        ACT_STOPPED: if (cur_phase == PH_CLEANING && hit && stop_needed) begin
          if (!ev.ok_flag) r.effect = go_restart();
          else begin
            armed         = 1'b0;
            rearm_wait    = 1'b0;
            stop_needed   = 1'b0;
            cleanup_ready = 1'b1;
            r.effect      = EF_INVALIDATE;
          end
        end
        ACT_CLEANUP: if (cur_phase == PH_CLEANING && hit && cleanup_ready && !stop_needed)
          clear_all();
        ACT_FIRED: if (cur_phase == PH_CLOSING && ticket_hit && armed && !rearm_wait) begin
          if ($signed(ev.now_time) >= $signed(cur_deadline)) r.effect = go_restart();
          else begin
            rearm_wait = 1'b1;
            r.effect   = EF_REARM;
          end
        end
        ACT_REARMED: if (cur_phase == PH_CLOSING && ticket_hit && rearm_wait) begin
          rearm_wait = 1'b0;
          if (!ev.ok_flag) r.effect = go_restart();
          else armed = 1'b1;
        end
        ACT_INIT: clear_all();
        default: ;
      endcase
      r.phase_now = cur_phase;
      pending_results.push_back(r);
    endfunction

    task report(input string msg);
      $display("%0t MISMATCH %s", $time, msg);
      errors++;
    endtask

    task check_result(input result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report("result beat with no event outstanding");
        return;
      end
      want = pending_results.pop_front();
      if (got.effect !== want.effect)
        report($sformatf("effect got %0d want %0d", got.effect, want.effect));
      if (got.accepted !== want.accepted)
        report($sformatf("accepted got %0d want %0d", got.accepted, want.accepted));
      if (got.time_left !== want.time_left)
        report($sformatf("time_left got %0h want %0h", got.time_left, want.time_left));
      if (got.deadline_out !== want.deadline_out)
        report($sformatf("deadline_out got %0h want %0h", got.deadline_out, want.deadline_out));
      if (got.phase_now !== want.phase_now)
        report($sformatf("phase_now got %0d want %0d", got.phase_now, want.phase_now));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [3:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  termination_scoreboard sb;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned idle_cycles;
  result_t     out_beat;

  link_termination_sequencer_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hold the event beat until the handshake, then update the prediction.
  task automatic send_event(input event_t ev);
    if ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= ev.action;
    s_tdata  <= {7'd0, ev.ok_flag, ev.ticket_deadline, ev.now_time, ev.new_gen_tag,
                 ev.gen_tag, ev.conn_handle};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_event(ev);
  endtask

  task automatic put(input logic [3:0] a, input logic [15:0] c,
                     input logic [63:0] g, input logic [63:0] ng,
                     input logic [63:0] nw, input logic [63:0] td, input logic ok);
    event_t ev;
    ev.action          = a;
    ev.conn_handle     = c;
    ev.gen_tag         = g;
    ev.new_gen_tag     = ng;
    ev.now_time        = nw;
    ev.ticket_deadline = td;
    ev.ok_flag         = ok;
    send_event(ev);
  endtask

  // Mostly events that fit the current phase and identity, with noise mixed in.
  function automatic event_t next_event();
    event_t  ev;
    action_t pool [8];
    case (sb.cur_phase)
      PH_CLOSED: pool = '{ACT_OPEN, ACT_OPEN, ACT_OPEN, ACT_OPEN, ACT_OPEN, ACT_OPEN,
                          ACT_ADMITS, ACT_CLEANUP};
      PH_OPEN: pool = '{ACT_ROTATE, ACT_ADMITS, ACT_BEGIN, ACT_BEGIN, ACT_BEGIN,
                        ACT_DISCONNECT, ACT_RESET, ACT_OPEN};
      PH_CLOSING: pool = '{ACT_TICKET, ACT_REMAINING, ACT_ARMED, ACT_GAP, ACT_FIRED,
                           ACT_FIRED, ACT_REARMED, ACT_DISCONNECT};
      PH_CLEANING: pool = '{ACT_STOPPED, ACT_STOPPED, ACT_CLEANUP, ACT_CLEANUP, ACT_CLEANUP,
                            ACT_DISCONNECT, ACT_RESET, ACT_TICKET};
      PH_RESTARTING: pool = '{ACT_INIT, ACT_INIT, ACT_INIT, ACT_INIT, ACT_INIT,
                              ACT_RESET, ACT_FIRED, ACT_OPEN};
      default: pool = '{default: ACT_INIT};
    endcase
    if ($urandom_range(0, 4) == 0) ev.action = 4'($urandom_range(0, 15));
    else ev.action = pool[$urandom_range(0, 7)];

    if (ev.action == ACT_OPEN) begin
      ev.conn_handle = 16'($urandom);
      ev.gen_tag = ($urandom_range(0, 9) == 0) ? 64'd0 : {$urandom, $urandom};
    end else begin
      ev.conn_handle = ($urandom_range(0, 9) < 8) ? sb.cur_handle : 16'($urandom);
      case ($urandom_range(0, 9))
        0: ev.gen_tag = '0;
        1: ev.gen_tag = {$urandom, $urandom};
        default: ev.gen_tag = sb.cur_gen;
      endcase
    end

    case ($urandom_range(0, 9))
      0: ev.new_gen_tag = '0;
      1: ev.new_gen_tag = ev.gen_tag;
      default: ev.new_gen_tag = {$urandom, $urandom};
    endcase

    case ($urandom_range(0, 5))
      0: ev.now_time = sb.cur_deadline + 64'($urandom_range(0, 6)) - 64'd3;
      1: ev.now_time = sb.cur_deadline - 64'($urandom);
      2: ev.now_time = {$urandom, $urandom};
      3: ev.now_time = S64_MAX - {32'd0, sb.period} + 64'($urandom_range(0, 4)) - 64'd2;
      4: ev.now_time = $urandom_range(0, 1) ? S64_MAX : S64_MIN;
      default: ev.now_time = 64'($urandom);
    endcase

    case ($urandom_range(0, 19))
      0: ev.ticket_deadline = {$urandom, $urandom};
      1: ev.ticket_deadline = sb.cur_deadline + 64'd1;
      default: ev.ticket_deadline = sb.cur_deadline;
    endcase

    ev.ok_flag = ($urandom_range(0, 3) != 0);
    return ev;
  endfunction

  task automatic run_random(input int unsigned count);
    repeat (count) send_event(next_event());
  endtask

  // Drop valid and wait out every outstanding result plus the pipeline depth.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.results_owed() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_period(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_PERIOD;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.period = value;
  endtask

  initial begin
    sb = new();
    gap_pct   = 20;
    stall_pct = 25;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed walk through open, rotate, close, watchdog, reset, init and cleanup paths
    put(ACT_ADMITS, 16'h0000, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0);
    put(ACT_OPEN, 16'hFFFF, '1, '0, '0, '0, 1'b1);
    put(ACT_ADMITS, 16'hFFFF, '1, '0, '0, '0, 1'b1);
    put(ACT_ROTATE, 16'hFFFF, '1, '1, '0, '0, 1'b1);
    put(ACT_ROTATE, 16'hFFFF, '1, '0, '0, '0, 1'b1);
    put(ACT_ROTATE, 16'hFFFF, '1, 64'd1, '0, '0, 1'b1);
    put(ACT_BEGIN, 16'hFFFF, 64'd1, '0, S64_MAX - 64'd10, '0, 1'b1);
    put(ACT_TICKET, 16'hFFFF, 64'd1, '0, '0, '0, 1'b1);
    put(ACT_REMAINING, 16'hFFFF, 64'd1, '0, S64_MIN, S64_MAX, 1'b1);
    put(ACT_ARMED, 16'hFFFF, 64'd1, '0, '0, S64_MAX, 1'b1);
    put(ACT_GAP, 16'hFFFF, 64'd1, '0, '0, S64_MAX, 1'b1);
    put(ACT_FIRED, 16'hFFFF, 64'd1, '0, 64'd0, S64_MAX, 1'b1);
    put(ACT_REARMED, 16'hFFFF, 64'd1, '0, 64'd0, S64_MAX, 1'b1);
    put(ACT_FIRED, 16'hFFFF, 64'd1, '0, S64_MAX, S64_MAX, 1'b1);
    put(ACT_RESET, 16'h0000, 64'd0, '0, '0, '0, 1'b0);
    put(ACT_UNDEF, 16'hFFFF, 64'd1, '1, '1, '1, 1'b1);
    put(ACT_INIT, 16'h1234, 64'd9, '0, '0, '0, 1'b0);
    put(ACT_OPEN, 16'h0000, 64'd5, '0, '0, '0, 1'b1);
    put(ACT_DISCONNECT, 16'h0000, 64'd5, '0, '0, '0, 1'b1);
    put(ACT_CLEANUP, 16'h0000, 64'd5, '0, '0, '0, 1'b1);
    put(ACT_OPEN, 16'h0000, 64'd7, '0, '0, '0, 1'b1);
    put(ACT_BEGIN, 16'h0000, 64'd7, '0, -64'sd1000, '0, 1'b1);
    put(ACT_RESET, 16'hABCD, 64'hDEAD_BEEF, '0, '0, '0, 1'b0);
    put(ACT_STOPPED, 16'h0000, 64'd7, '0, '0, '0, 1'b1);
    put(ACT_CLEANUP, 16'h0000, 64'd7, '0, '0, '0, 1'b1);

    run_random(130);

    drain();
    write_period(32'd1);
    gap_pct   = 40;
    stall_pct = 10;
    run_random(150);

    drain();
    write_period(32'hFFFF_FFFF);
    gap_pct   = 5;
    stall_pct = 40;
    run_random(150);

    drain();
    write_period($urandom_range(2, 32'hFFFF_FFFE));
    gap_pct   = 15;
    stall_pct = 15;
    run_random(150);

    // close out at full rate on both sides
    drain();
    write_period($urandom_range(1, 20));
    gap_pct   = 0;
    stall_pct = 0;
    run_random(150);

    drain();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      out_beat.effect       = m_tdata[2:0];
      out_beat.accepted     = m_tdata[3];
      out_beat.time_left    = m_tdata[66:4];
      out_beat.deadline_out = m_tdata[130:67];
      out_beat.phase_now    = m_tdata[133:131];
      sb.check_result(out_beat);
    end
  end

  // End the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: link_termination_sequencer_core.f
sv/lts_pkg.sv
sv/lts_fsm.sv
sv/link_termination_sequencer_core.sv
sv/lts_checker.sv
sim/tb_link_termination_sequencer_core.sv
